// ===== src/sam_pkg.sv =====
`default_nettype none
package sam_pkg;

  localparam int MAX_TEXT   = 4096;
  localparam int ALPHABET   = 26;
  localparam int NODE_SLOTS = 2 * MAX_TEXT;
  localparam int NODE_W     = 13;
  localparam int LETTER_W   = 5;
  localparam int TLEN_W     = 13;
  localparam int ROW_W      = ALPHABET * NODE_W;
  localparam int NREC_W     = 2 * NODE_W;

  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_LETTER = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_BAD_NODE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_CHK,
    ST_CL2,
    ST_REDIR,
    ST_RDQ
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [LETTER_W-1:0] letter;
    logic [NODE_W-1:0]   node_sel;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] link_id;
    logic [NODE_W-1:0] node_length;
    logic [NODE_W-1:0] next_id;
    logic [NODE_W-1:0] clone_id;
  } rsp_t;

  // one transition row: target node per letter
  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  // per-node record
  typedef struct packed {
    logic [NODE_W-1:0] link;
    logic [NODE_W-1:0] len;
  } nrec_t;

endpackage
`default_nettype wire

// ===== src/sam_ram.sv =====
`default_nettype none
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/suffix_automaton_builder.sv =====
// Channel | Direction | Handshake            | Payload
// in_     | request   | in_valid / in_ready  | req_t  (op, letter, node_sel)
// out_    | result    | out_valid / out_ready| rsp_t  (status .. clone_id)
//
// One request at a time. An append first allocates the new state, then walks
// the suffix links, adding the missing transition at each step until it finds
// one or runs out of links; it then checks the length, and on a clone relinks
// q and redirects transitions to the clone until the walk meets another target.
// After reset, the root row and record are initialised before requests.
// A waiting result blocks new requests until it is taken.
`default_nettype none
module suffix_automaton_builder
  import sam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  state_t state_r, state_nxt;
  logic [NODE_W-1:0]   p_r, p_nxt, q_r, q_nxt, cur_r, cur_nxt, cl_r, cl_nxt;
  logic [NODE_W-1:0]   plen_r, plen_nxt, lenq_r, lenq_nxt;
  logic [NODE_W-1:0]   sc_r, sc_nxt, last_r, last_nxt;
  logic [TLEN_W-1:0]   tlen_r, tlen_nxt;
  logic [LETTER_W-1:0] ch_r, ch_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_data_r, out_data_nxt;

  logic              t_we, n_we;
  logic [NODE_W-1:0] t_waddr, t_raddr, n_waddr, n_raddr;
  row_t              t_wdata, t_rdata, row_mod;
  nrec_t             n_wdata, n_rdata;
  logic [NODE_W-1:0] tgt;
  logic              in_fire;

  // transition rows, one per node
  sam_ram #(.WIDTH(ROW_W), .DEPTH(NODE_SLOTS)) u_trans (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // link and length per node
  sam_ram #(.WIDTH(NREC_W), .DEPTH(NODE_SLOTS)) u_node (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // hold state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sc_r        <= ROOT_NODE;
      last_r      <= ROOT_NODE;
      tlen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      last_r      <= last_nxt;
      tlen_r      <= tlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    cur_r      <= cur_nxt;
    cl_r       <= cl_nxt;
    plen_r     <= plen_nxt;
    lenq_r     <= lenq_nxt;
    ch_r       <= ch_nxt;
    out_data_r <= out_data_nxt;
  end

  assign tgt = t_rdata[ch_r];

  // sequence the walk, clone and redirect steps
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    cur_nxt       = cur_r;
    cl_nxt        = cl_r;
    plen_nxt      = plen_r;
    lenq_nxt      = lenq_r;
    sc_nxt        = sc_r;
    last_nxt      = last_r;
    tlen_nxt      = tlen_r;
    ch_nxt        = ch_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    t_we          = 1'b0;
    t_waddr       = p_r;
    t_wdata       = t_rdata;
    t_raddr       = p_r;
    n_we          = 1'b0;
    n_waddr       = cur_r;
    n_wdata       = '{link: '0, len: '0};
    n_raddr       = p_r;
    row_mod       = t_rdata;

    unique case (state_r)
      ST_INIT: begin
        // clear the root row and record
        t_we      = 1'b1;
        t_waddr   = ROOT_NODE;
        t_wdata   = '0;
        n_we      = 1'b1;
        n_waddr   = ROOT_NODE;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        ch_nxt = in_data.letter;
        if (in_fire) begin
          if (in_data.op == OP_APPEND) begin
            if (32'(in_data.letter) >= ALPHABET) begin
              out_data_nxt  = '{status: STAT_BAD_LETTER, default: '0};
              out_valid_nxt = 1'b1;
            end else if (32'(tlen_r) >= MAX_TEXT) begin
              out_data_nxt  = '{status: STAT_FULL, default: '0};
              out_valid_nxt = 1'b1;
            end else begin
              // allocate the new state and start the link walk
              cur_nxt   = sc_r + NODE_W'(1);
              sc_nxt    = cur_nxt;
              last_nxt  = cur_nxt;
              tlen_nxt  = tlen_r + TLEN_W'(1);
              cl_nxt    = '0;
              t_we      = 1'b1;
              t_waddr   = cur_nxt;
              t_wdata   = '0;
              n_we      = 1'b1;
              n_waddr   = cur_nxt;
              n_wdata   = '{link: '0, len: NODE_W'(tlen_nxt)};
              p_nxt     = last_r;
              t_raddr   = last_r;
              n_raddr   = last_r;
              state_nxt = ST_WALK;
            end
          end else if (in_data.node_sel == '0 || in_data.node_sel > sc_r) begin
            out_data_nxt  = '{status: STAT_BAD_NODE, default: '0};
            out_valid_nxt = 1'b1;
          end else begin
            p_nxt     = in_data.node_sel;
            t_raddr   = in_data.node_sel;
            n_raddr   = in_data.node_sel;
            state_nxt = ST_RDQ;
          end
        end
      end
      ST_WALK: begin
        if (tgt == '0) begin
          // add the missing transition and follow the link
          row_mod[ch_r] = cur_r;
          t_we          = 1'b1;
          t_wdata       = row_mod;
          p_nxt         = n_rdata.link;
          t_raddr       = n_rdata.link;
          n_raddr       = n_rdata.link;
          if (n_rdata.link == '0) begin
            n_we          = 1'b1;
            n_wdata       = '{link: ROOT_NODE, len: NODE_W'(tlen_r)};
            out_data_nxt  = '{status: STAT_OK, node_id: cur_r, link_id: ROOT_NODE,
                              node_length: NODE_W'(tlen_r), default: '0};
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          q_nxt     = tgt;
          plen_nxt  = n_rdata.len + NODE_W'(1);
          t_raddr   = tgt;
          n_raddr   = tgt;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (n_rdata.len == plen_r) begin
          n_we          = 1'b1;
          n_wdata       = '{link: q_r, len: NODE_W'(tlen_r)};
          out_data_nxt  = '{status: STAT_OK, node_id: cur_r, link_id: q_r,
                            node_length: NODE_W'(tlen_r), default: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          // clone q: copy its row, link and the shorter length
          cl_nxt    = sc_r + NODE_W'(1);
          sc_nxt    = cl_nxt;
          lenq_nxt  = n_rdata.len;
          n_we      = 1'b1;
          n_waddr   = cl_nxt;
          n_wdata   = '{link: n_rdata.link, len: plen_r};
          t_we      = 1'b1;
          t_waddr   = cl_nxt;
          t_wdata   = t_rdata;
          state_nxt = ST_CL2;
        end
      end
      ST_CL2: begin
        // relink q to the clone and reread p
        n_we      = 1'b1;
        n_waddr   = q_r;
        n_wdata   = '{link: cl_r, len: lenq_r};
        state_nxt = ST_REDIR;
      end
      ST_REDIR: begin
        n_we    = 1'b1;
        n_wdata = '{link: cl_r, len: NODE_W'(tlen_r)};
        if (tgt == q_r) begin
          row_mod[ch_r] = cl_r;
          t_we          = 1'b1;
          t_wdata       = row_mod;
          p_nxt         = n_rdata.link;
          t_raddr       = n_rdata.link;
          n_raddr       = n_rdata.link;
        end
        if (tgt != q_r || n_rdata.link == '0) begin
          out_data_nxt  = '{status: STAT_OK, node_id: cur_r, link_id: cl_r,
                            node_length: NODE_W'(tlen_r), next_id: '0, clone_id: cl_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RDQ: begin
        out_data_nxt = '{status: STAT_OK, node_id: p_r, link_id: n_rdata.link,
                         node_length: n_rdata.len, next_id: '0, clone_id: '0};
        if (32'(ch_r) >= ALPHABET) begin
          out_data_nxt.status = STAT_BAD_LETTER;
        end else begin
          out_data_nxt.next_id = tgt;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("request taken outside idle");
  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> sc_r >= $past(sc_r))
    else $error("state count went down");
  a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tlen_r) <= MAX_TEXT)
    else $error("text length beyond capacity");
  a_clone_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.clone_id != '0) |->
      out_data_r.clone_id == out_data_r.node_id + NODE_W'(1))
    else $error("clone not allocated after new state");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb
  import sam_pkg::*;
;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  suffix_automaton_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  localparam int IDLE_LIMIT = 40000;

  // shadow automaton
  logic [NODE_W-1:0] sh_trans [NODE_SLOTS][ALPHABET];
  logic [NODE_W-1:0] sh_link [NODE_SLOTS];
  logic [NODE_W-1:0] sh_len [NODE_SLOTS];
  int unsigned sh_count, sh_last, sh_text;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  int n_appends = 0, n_clones = 0, n_reads = 0, n_rejects = 0;

  task automatic sam_clear();
    for (int i = 0; i < NODE_SLOTS; i++) begin
      sh_link[i] = '0;
      sh_len[i] = '0;
      for (int c = 0; c < ALPHABET; c++) sh_trans[i][c] = '0;
    end
    sh_count = 1;
    sh_last = 1;
    sh_text = 0;
  endtask

  // compute the result of one request and advance the shadow automaton
  function automatic rsp_t sam_predict(req_t r);
    rsp_t o;
    int unsigned p, cur, q, cl, plen, guard, ch;
    o = '0;
    ch = r.letter;
    if (r.op == OP_APPEND) begin
      if (ch >= ALPHABET) begin
        o.status = STAT_BAD_LETTER;
        n_rejects++;
        return o;
      end
      if (sh_text >= MAX_TEXT) begin
        o.status = STAT_FULL;
        n_rejects++;
        return o;
      end
      n_appends++;
      p = sh_last;
      cur = sh_count + 1;
      sh_count = cur;
      sh_last = cur;
      sh_text++;
      sh_len[cur] = NODE_W'(sh_text);
      sh_link[cur] = '0;
      cl = 0;
      guard = sh_count;
      while (p != 0 && sh_trans[p][ch] == 0 && guard != 0) begin
        sh_trans[p][ch] = NODE_W'(cur);
        p = sh_link[p];
        guard--;
      end
      if (p == 0) sh_link[cur] = ROOT_NODE;
      else begin
        q = sh_trans[p][ch];
        plen = sh_len[p] + 1;
        if (sh_len[q] == plen) sh_link[cur] = NODE_W'(q);
        else begin
          cl = sh_count + 1;
          sh_count = cl;
          sh_len[cl] = NODE_W'(plen);
          sh_link[cl] = sh_link[q];
          for (int c = 0; c < ALPHABET; c++) sh_trans[cl][c] = sh_trans[q][c];
          sh_link[q] = NODE_W'(cl);
          sh_link[cur] = NODE_W'(cl);
          guard = sh_count;
          while (p != 0 && sh_trans[p][ch] == q && guard != 0) begin
            sh_trans[p][ch] = NODE_W'(cl);
            p = sh_link[p];
            guard--;
          end
          n_clones++;
        end
      end
      o.status = STAT_OK;
      o.node_id = NODE_W'(cur);
      o.link_id = sh_link[cur];
      o.node_length = sh_len[cur];
      o.next_id = sh_trans[cur][ch];
      o.clone_id = NODE_W'(cl);
      return o;
    end
    n_reads++;
    if (r.node_sel == 0 || r.node_sel > sh_count || r.node_sel >= NODE_SLOTS) begin
      o.status = STAT_BAD_NODE;
      return o;
    end
    o.node_id = r.node_sel;
    o.link_id = sh_link[r.node_sel];
    o.node_length = sh_len[r.node_sel];
    if (ch >= ALPHABET) o.status = STAT_BAD_LETTER;
    else begin
      o.status = STAT_OK;
      o.next_id = sh_trans[r.node_sel][ch];
    end
    return o;
  endfunction

  function automatic req_t mk_req(op_t op, int letter, int sel);
    req_t r;
    r.op = op;
    r.letter = letter[LETTER_W-1:0];
    r.node_sel = sel[NODE_W-1:0];
    return r;
  endfunction

  // driver: offer the head of the queue, hold until accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(sam_predict(in_data));
        void'(pending_reqs.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold request
      end else if (pending_reqs.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check results and randomise the ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result %p", out_data);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (out_data.status != e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status); errors++;
          end
          if (out_data.node_id != e.node_id) begin
            $error("node_id exp %0d got %0d", e.node_id, out_data.node_id); errors++;
          end
          if (out_data.link_id != e.link_id) begin
            $error("link_id exp %0d got %0d", e.link_id, out_data.link_id); errors++;
          end
          if (out_data.node_length != e.node_length) begin
            $error("node_length exp %0d got %0d", e.node_length, out_data.node_length);
            errors++;
          end
          if (out_data.next_id != e.next_id) begin
            $error("next_id exp %0d got %0d", e.next_id, out_data.next_id); errors++;
          end
          if (out_data.clone_id != e.clone_id) begin
            $error("clone_id exp %0d got %0d", e.clone_id, out_data.clone_id); errors++;
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: count cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  // push a random request; mostly well-formed appends over a small alphabet
  task automatic push_random();
    int k;
    k = $urandom_range(99);
    if (k < 55) pending_reqs.push_back(mk_req(OP_APPEND, $urandom_range(2), 0));
    else if (k < 65) pending_reqs.push_back(mk_req(OP_APPEND, $urandom_range(25), 0));
    else if (k < 70) pending_reqs.push_back(mk_req(OP_APPEND, $urandom_range(31, 26), 0));
    else if (k < 92)
      pending_reqs.push_back(mk_req(OP_READ, $urandom_range(25), $urandom_range(sh_count + 40)));
    else pending_reqs.push_back(mk_req(OP_READ, $urandom_range(31), $urandom_range(8191)));
  endtask

  initial begin
    sam_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty reads, bad letter, a clone-forming word, extremes
    pending_reqs.push_back(mk_req(OP_READ, 0, 1));
    pending_reqs.push_back(mk_req(OP_READ, 0, 0));
    pending_reqs.push_back(mk_req(OP_READ, 31, 8191));
    pending_reqs.push_back(mk_req(OP_APPEND, 26, 0));
    pending_reqs.push_back(mk_req(OP_APPEND, 31, 8191));
    pending_reqs.push_back(mk_req(OP_APPEND, 0, 0));
    pending_reqs.push_back(mk_req(OP_APPEND, 1, 0));
    pending_reqs.push_back(mk_req(OP_APPEND, 1, 0));
    pending_reqs.push_back(mk_req(OP_APPEND, 0, 0));
    pending_reqs.push_back(mk_req(OP_APPEND, 1, 5461));
    pending_reqs.push_back(mk_req(OP_APPEND, 25, 0));
    pending_reqs.push_back(mk_req(OP_READ, 0, 1));
    pending_reqs.push_back(mk_req(OP_READ, 1, 3));
    pending_reqs.push_back(mk_req(OP_READ, 25, 4));
    pending_reqs.push_back(mk_req(OP_READ, 30, 2));
    pending_reqs.push_back(mk_req(OP_READ, 0, 10));
    pending_reqs.push_back(mk_req(OP_READ, 0, 4096));
    wait_drained();

    // random phases with varying idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        3: begin send_idle_pct = 12; recv_stall_pct = 12; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 125; i++) push_random();
      if (ph == 4) begin
        // hold the receiver off while requests keep arriving
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d appends (%0d clones), %0d reads, %0d rejected appends",
             n_appends, n_clones, n_reads, n_rejects);
    $display("automaton reached %0d nodes over a text of %0d letters", sh_count, sh_text);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
